>>> rtl/wcsp_pkg.sv
package wcsp_pkg;

    localparam logic [31:0] TAG_WAVE = 32'h5741_5645;
    localparam logic [31:0] TAG_FMT  = 32'h666D_7420;
    localparam logic [31:0] TAG_DATA = 32'h6461_7461;

    localparam logic [15:0] ENC_PCM  = 16'd1;
    localparam logic [15:0] ENC_ULAW = 16'd7;

    localparam logic KIND_SAMPLE = 1'b0;
    localparam logic KIND_ERROR  = 1'b1;

    localparam logic [2:0] FMT_NONE     = 3'd0;
    localparam logic [2:0] FMT_MONO8    = 3'd1;
    localparam logic [2:0] FMT_MONO16   = 3'd2;
    localparam logic [2:0] FMT_STEREO8  = 3'd3;
    localparam logic [2:0] FMT_STEREO16 = 3'd4;

    localparam logic [2:0] ERR_NONE      = 3'd0;
    localparam logic [2:0] ERR_NOT_WAVE  = 3'd1;
    localparam logic [2:0] ERR_ULAW      = 3'd2;
    localparam logic [2:0] ERR_ENCODING  = 3'd3;
    localparam logic [2:0] ERR_NO_FMT    = 3'd4;
    localparam logic [2:0] ERR_TRUNCATED = 3'd5;

    typedef struct packed {
        logic [7:0] file_byte;
        logic       end_of_file;
    } in_item_t;

    typedef struct packed {
        logic        item_kind;
        logic [15:0] sample_value;
        logic        final_sample;
        logic [2:0]  format_code;
        logic [31:0] sample_rate;
        logic [15:0] sample_bits;
        logic [15:0] channels;
        logic [2:0]  error_code;
    } result_t;

    function automatic logic [2:0] fmt_code(input logic [15:0] chans, input logic [15:0] bits);
        logic [2:0] code;
        code = FMT_NONE;
        if (chans == 16'd1 && bits == 16'd8) code = FMT_MONO8;
        else if (chans == 16'd1 && bits == 16'd16) code = FMT_MONO16;
        else if (chans == 16'd2 && bits == 16'd8) code = FMT_STEREO8;
        else if (chans == 16'd2 && bits == 16'd16) code = FMT_STEREO16;
        return code;
    endfunction

endpackage

>>> rtl/wcsp_byte_if.sv
interface wcsp_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] file_byte;
    logic       end_of_file;

    modport source (output valid, output file_byte, output end_of_file, input ready);
    modport sink (input valid, input file_byte, input end_of_file, output ready);
endinterface

>>> rtl/wcsp_result_if.sv
interface wcsp_result_if;
    logic        valid;
    logic        ready;
    logic        item_kind;
    logic [15:0] sample_value;
    logic        final_sample;
    logic [2:0]  format_code;
    logic [31:0] sample_rate;
    logic [15:0] sample_bits;
    logic [15:0] channels;
    logic [2:0]  error_code;

    modport source (output valid, output item_kind, output sample_value, output final_sample,
                    output format_code, output sample_rate, output sample_bits,
                    output channels, output error_code, input ready);
    modport sink (input valid, input item_kind, input sample_value, input final_sample,
                  input format_code, input sample_rate, input sample_bits,
                  input channels, input error_code, output ready);
endinterface

>>> rtl/wcsp_in_reg.sv
module wcsp_in_reg (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              valid,
    output logic              ready,
    input  wcsp_pkg::in_item_t item,
    input  logic              advance,
    output logic              held_valid,
    output wcsp_pkg::in_item_t held_item
);
    import wcsp_pkg::*;

    logic     valid_reg;
    logic     valid_next;
    in_item_t item_reg;

    assign ready      = !valid_reg || advance;
    assign held_valid = valid_reg;
    assign held_item  = item_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (ready)
        begin
            valid_next = valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ready && valid)
        begin
            item_reg <= item;
        end
    end

endmodule

>>> rtl/wcsp_parser.sv
module wcsp_parser (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               step,
    input  wcsp_pkg::in_item_t item,
    output logic               has_result,
    output wcsp_pkg::result_t  result
);
    import wcsp_pkg::*;

    typedef enum logic [3:0] {
        PH_SKIP  = 4'd0,
        PH_RLEN  = 4'd1,
        PH_WAVE  = 4'd2,
        PH_TAG   = 4'd3,
        PH_LEN   = 4'd4,
        PH_ENC   = 4'd5,
        PH_CH    = 4'd6,
        PH_RATE  = 4'd7,
        PH_BRATE = 4'd8,
        PH_ALIGN = 4'd9,
        PH_BITS  = 4'd10,
        PH_FEXT  = 4'd11,
        PH_CSKIP = 4'd12,
        PH_DATA  = 4'd13,
        PH_DONE  = 4'd14
    } phase_t;

    phase_t      phase_reg, phase_next;
    logic [2:0]  count_reg, count_next;
    logic [31:0] tag_reg, tag_next;
    logic [31:0] left_reg, left_next;
    logic [15:0] enc_reg, enc_next;
    logic [15:0] chan_reg, chan_next;
    logic [31:0] rate_reg, rate_next;
    logic [15:0] bits_reg, bits_next;
    logic        seen_reg, seen_next;
    logic        pair_reg, pair_next;
    logic [7:0]  low_reg, low_next;
    logic        odd_reg, odd_next;

    logic [2:0]  err;
    logic        have_sample;
    logic        fin;
    logic [15:0] sval;
    logic [2:0]  cnt;
    logic [2:0]  width;
    logic [31:0] left_dec;
    logic [31:0] byte_shift;
    logic [7:0]  b;

    assign b          = item.file_byte;
    assign left_dec   = (left_reg != 32'd0) ? left_reg - 32'd1 : 32'd0;
    assign byte_shift = {24'd0, b} << {count_reg[1:0], 3'b000};

    always_comb
    begin
        phase_next  = phase_reg;
        tag_next    = tag_reg;
        left_next   = left_reg;
        enc_next    = enc_reg;
        chan_next   = chan_reg;
        rate_next   = rate_reg;
        bits_next   = bits_reg;
        seen_next   = seen_reg;
        pair_next   = pair_reg;
        low_next    = low_reg;
        odd_next    = odd_reg;
        err         = ERR_NONE;
        have_sample = 1'b0;
        fin         = 1'b0;
        sval        = 16'd0;
        cnt         = count_reg + 3'd1;
        width       = (phase_reg == PH_RATE || phase_reg == PH_BRATE) ? 3'd4 : 3'd2;
        has_result  = 1'b0;
        result      = '0;

        case (phase_reg)
            PH_SKIP, PH_RLEN:
            begin
                if (cnt == 3'd4)
                begin
                    cnt        = 3'd0;
                    phase_next = (phase_reg == PH_SKIP) ? PH_RLEN : PH_WAVE;
                end
            end
            PH_WAVE, PH_TAG:
            begin
                tag_next = {tag_reg[23:0], b};
                if (cnt == 3'd4)
                begin
                    cnt = 3'd0;
                    if (phase_reg == PH_WAVE)
                    begin
                        if (tag_next != TAG_WAVE) err = ERR_NOT_WAVE;
                        else phase_next = PH_TAG;
                    end
                    else
                    begin
                        left_next  = 32'd0;
                        phase_next = PH_LEN;
                    end
                end
            end
            PH_LEN:
            begin
                left_next = ((count_reg == 3'd0) ? 32'd0 : left_reg) | byte_shift;
                if (cnt == 3'd4)
                begin
                    cnt = 3'd0;
                    if (tag_reg == TAG_FMT)
                    begin
                        seen_next  = 1'b1;
                        phase_next = PH_ENC;
                    end
                    else if (tag_reg == TAG_DATA)
                    begin
                        if (!seen_reg) err = ERR_NO_FMT;
                        else
                        begin
                            odd_next   = 1'b0;
                            phase_next = (left_next == 32'd0) ? PH_DONE : PH_DATA;
                        end
                    end
                    else
                    begin
                        phase_next = (left_next == 32'd0) ? PH_TAG : PH_CSKIP;
                    end
                end
            end
            PH_ENC, PH_CH, PH_RATE, PH_BRATE, PH_ALIGN, PH_BITS:
            begin
                left_next = left_dec;
                case (phase_reg)
                    PH_ENC:
                        enc_next = ((count_reg == 3'd0) ? 16'd0 : enc_reg) | byte_shift[15:0];
                    PH_CH:
                        chan_next = ((count_reg == 3'd0) ? 16'd0 : chan_reg) | byte_shift[15:0];
                    PH_RATE:
                        rate_next = ((count_reg == 3'd0) ? 32'd0 : rate_reg) | byte_shift;
                    PH_BITS:
                        bits_next = ((count_reg == 3'd0) ? 16'd0 : bits_reg) | byte_shift[15:0];
                    default:
                    begin
                    end
                endcase
                if (cnt >= width)
                begin
                    cnt = 3'd0;
                    case (phase_reg)
                        PH_ENC:   phase_next = PH_CH;
                        PH_CH:    phase_next = PH_RATE;
                        PH_RATE:  phase_next = PH_BRATE;
                        PH_BRATE: phase_next = PH_ALIGN;
                        PH_ALIGN: phase_next = PH_BITS;
                        default:
                        begin
                            if (enc_reg == ENC_PCM)
                            begin
                                pair_next  = (bits_next != 16'd8);
                                phase_next = (left_dec == 32'd0) ? PH_TAG : PH_FEXT;
                            end
                            else if (enc_reg == ENC_ULAW) err = ERR_ULAW;
                            else err = ERR_ENCODING;
                        end
                    endcase
                end
            end
            PH_FEXT, PH_CSKIP:
            begin
                cnt       = count_reg;
                left_next = left_dec;
                if (left_dec == 32'd0) phase_next = PH_TAG;
            end
            PH_DATA:
            begin
                cnt       = count_reg;
                left_next = left_dec;
                fin       = (left_dec == 32'd0);
                if (!pair_reg)
                begin
                    have_sample = 1'b1;
                    sval        = {8'd0, b};
                end
                else if (!odd_reg)
                begin
                    low_next = b;
                    odd_next = 1'b1;
                    if (fin)
                    begin
                        have_sample = 1'b1;
                        sval        = {8'd0, b};
                        odd_next    = 1'b0;
                    end
                end
                else
                begin
                    have_sample = 1'b1;
                    sval        = {b, low_reg};
                    odd_next    = 1'b0;
                end
                if (fin) phase_next = PH_DONE;
            end
            default:
            begin
                cnt = count_reg;
            end
        endcase

        if (err != ERR_NONE) phase_next = PH_DONE;
        count_next = cnt;

        if (err == ERR_NONE && item.end_of_file && phase_next != PH_DONE)
        begin
            err = ERR_TRUNCATED;
        end
        if (err != ERR_NONE)
        begin
            has_result        = 1'b1;
            result.item_kind  = KIND_ERROR;
            result.error_code = err;
        end
        else if (have_sample)
        begin
            has_result          = 1'b1;
            result.item_kind    = KIND_SAMPLE;
            result.sample_value = sval;
            result.final_sample = fin;
            result.format_code  = fmt_code(chan_next, bits_next);
            result.sample_rate  = rate_next;
            result.sample_bits  = bits_next;
            result.channels     = chan_next;
            result.error_code   = ERR_NONE;
        end

        if (item.end_of_file)
        begin
            phase_next = PH_SKIP;
            count_next = 3'd0;
            tag_next   = 32'd0;
            left_next  = 32'd0;
            enc_next   = 16'd0;
            chan_next  = 16'd0;
            rate_next  = 32'd0;
            bits_next  = 16'd0;
            seen_next  = 1'b0;
            pair_next  = 1'b0;
            low_next   = 8'd0;
            odd_next   = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_SKIP;
            count_reg <= 3'd0;
            tag_reg   <= 32'd0;
            left_reg  <= 32'd0;
            enc_reg   <= 16'd0;
            chan_reg  <= 16'd0;
            rate_reg  <= 32'd0;
            bits_reg  <= 16'd0;
            seen_reg  <= 1'b0;
            pair_reg  <= 1'b0;
            low_reg   <= 8'd0;
            odd_reg   <= 1'b0;
        end
        else if (step)
        begin
            phase_reg <= phase_next;
            count_reg <= count_next;
            tag_reg   <= tag_next;
            left_reg  <= left_next;
            enc_reg   <= enc_next;
            chan_reg  <= chan_next;
            rate_reg  <= rate_next;
            bits_reg  <= bits_next;
            seen_reg  <= seen_next;
            pair_reg  <= pair_next;
            low_reg   <= low_next;
            odd_reg   <= odd_next;
        end
    end

endmodule

>>> rtl/wcsp_out_reg.sv
module wcsp_out_reg (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              load,
    input  logic              has_result,
    input  wcsp_pkg::result_t result,
    output logic              free,
    output logic              valid,
    input  logic              ready,
    output wcsp_pkg::result_t held
);
    import wcsp_pkg::*;

    logic    valid_reg;
    logic    valid_next;
    result_t data_reg;

    assign free  = !valid_reg || ready;
    assign valid = valid_reg;
    assign held  = data_reg;

    always_comb
    begin
        valid_next = valid_reg && !ready;
        if (load)
        begin
            valid_next = has_result;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load && has_result)
        begin
            data_reg <= result;
        end
    end

endmodule

>>> rtl/wave_chunk_stream_parser.sv
// WAV byte stream parser.
// byte_in carries one file byte per item with end_of_file marking the last
// byte of a file. result_out carries sample items and error items; a byte
// gives at most one result item, and most header bytes give none.
// An accepted byte is held in an input register and parsed from there once
// the output register is free; its result is loaded into the output register
// as the byte leaves the input register, and result_out is driven from there.
// One byte is accepted every cycle while the output register is free or
// being drained; each byte is parsed combinationally from the input
// register, so the sustained rate is one byte per cycle.
// When result_out stalls with a result waiting, the parse stage stops and
// byte_in.ready drops once the input register is also full; nothing is lost.
// Reset clears the valid flags of both registers and returns the parser to
// the start of a file. After any error the rest of the file is ignored up to
// the byte marked end_of_file, and after that byte the parser starts a new file.
module wave_chunk_stream_parser (
    input  logic clk,
    input  logic rst_n,
    wcsp_byte_if.sink     byte_in,
    wcsp_result_if.source result_out
);
    import wcsp_pkg::*;

    in_item_t in_item;
    in_item_t held_item;
    logic     held_valid;
    logic     advance;
    logic     out_free;
    logic     has_result;
    result_t  result;
    result_t  out_data;

    assign in_item.file_byte   = byte_in.file_byte;
    assign in_item.end_of_file = byte_in.end_of_file;
    assign advance             = held_valid && out_free;

    wcsp_in_reg u_in_reg (
        .clk        (clk),
        .rst_n      (rst_n),
        .valid      (byte_in.valid),
        .ready      (byte_in.ready),
        .item       (in_item),
        .advance    (advance),
        .held_valid (held_valid),
        .held_item  (held_item)
    );

    wcsp_parser u_parser (
        .clk        (clk),
        .rst_n      (rst_n),
        .step       (advance),
        .item       (held_item),
        .has_result (has_result),
        .result     (result)
    );

    wcsp_out_reg u_out_reg (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (advance),
        .has_result (has_result),
        .result     (result),
        .free       (out_free),
        .valid      (result_out.valid),
        .ready      (result_out.ready),
        .held       (out_data)
    );

    assign result_out.item_kind    = out_data.item_kind;
    assign result_out.sample_value = out_data.sample_value;
    assign result_out.final_sample = out_data.final_sample;
    assign result_out.format_code  = out_data.format_code;
    assign result_out.sample_rate  = out_data.sample_rate;
    assign result_out.sample_bits  = out_data.sample_bits;
    assign result_out.channels     = out_data.channels;
    assign result_out.error_code   = out_data.error_code;

endmodule

>>> rtl/wcsp_checker.sv
module wcsp_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_ready,
    input logic        item_kind,
    input logic [15:0] sample_value,
    input logic        final_sample,
    input logic [2:0]  format_code,
    input logic [31:0] sample_rate,
    input logic [15:0] sample_bits,
    input logic [15:0] channels,
    input logic [2:0]  error_code
);
    import wcsp_pkg::*;

    a_valid_holds: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result valid dropped while stalled");

    a_payload_holds: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(sample_value) && $stable(error_code)
            && $stable(item_kind))
        else $error("result payload changed while stalled");

    a_error_clean: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && item_kind == KIND_ERROR |-> error_code != ERR_NONE
            && sample_value == 16'd0 && !final_sample && format_code == FMT_NONE
            && sample_rate == 32'd0 && sample_bits == 16'd0 && channels == 16'd0)
        else $error("error item carries sample fields");

    a_sample_clean: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && item_kind == KIND_SAMPLE |-> error_code == ERR_NONE
            && format_code == fmt_code(channels, sample_bits))
        else $error("sample item fields inconsistent");

endmodule

bind wave_chunk_stream_parser wcsp_checker u_wcsp_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .out_valid    (result_out.valid),
    .out_ready    (result_out.ready),
    .item_kind    (result_out.item_kind),
    .sample_value (result_out.sample_value),
    .final_sample (result_out.final_sample),
    .format_code  (result_out.format_code),
    .sample_rate  (result_out.sample_rate),
    .sample_bits  (result_out.sample_bits),
    .channels     (result_out.channels),
    .error_code   (result_out.error_code)
);
